// ===== rtl/core/tdb_pkg.sv =====
// ----------------------------------------------------------------------------
// Transfer descriptor builder package
// Item types, packet identifiers and field widths shared by the block.
// ----------------------------------------------------------------------------
package tdb_pkg;

  localparam int CountW = 16;
  localparam int MaxpW  = 10;
  localparam int LenW   = 11;
  localparam int AddrW  = 32;

  localparam logic [1:0] PID_SETUP = 2'd0;
  localparam logic [1:0] PID_IN    = 2'd1;
  localparam logic [1:0] PID_OUT   = 2'd2;

  localparam logic [LenW-1:0] ZERO_LEN_CODE  = 11'h7FF;
  localparam logic [LenW-1:0] SETUP_LEN_CODE = 11'd7;

  typedef struct packed {
    logic              func;
    logic              direction;
    logic [6:0]        device_address;
    logic [3:0]        endpoint;
    logic [CountW-1:0] byte_count;
    logic [MaxpW-1:0]  max_packet;
    logic [AddrW-1:0]  buffer_address;
    logic [AddrW-1:0]  setup_address;
  } req_t;

  typedef struct packed {
    logic [1:0]       packet_id;
    logic             data_toggle;
    logic [6:0]       target_address;
    logic [3:0]       target_endpoint;
    logic [LenW-1:0]  length_code;
    logic             short_detect;
    logic             interrupt_on_complete;
    logic [AddrW-1:0] data_address;
    logic             rejected;
    logic             last;
  } desc_t;

  typedef struct packed {
    req_t req;
    logic reject;
  } cmd_t;

endpackage

// ===== rtl/core/usb_transfer_descriptor_builder.sv =====
// ----------------------------------------------------------------------------
// USB transfer descriptor builder
// Turns each transfer request into its sequence of transfer descriptors.
// ----------------------------------------------------------------------------
// Requests enter through a two-deep command queue and descriptors leave
// through a two-deep result queue, so both sides stall on their own. The
// back-end sequencer loads a request in its idle state and then emits one
// descriptor per cycle while the result queue is not full. A rejected
// request yields one rejected descriptor; an empty bulk request is dropped
// by the front end and yields no descriptors.
module usb_transfer_descriptor_builder
  import tdb_pkg::*;
#(
  parameter int MAX_PACKETS = 62
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push,
  output logic  full,
  input  req_t  req_i,
  output logic  empty,
  input  logic  pop,
  output desc_t desc_o
);

  cmd_t  front_cmd, back_cmd;
  logic  front_push;
  logic  cmd_empty, cmd_pop;
  desc_t back_desc;
  logic  back_valid, out_full;

  tdb_front #(
    .MAX_PACKETS(MAX_PACKETS)
  ) u_front (
    .req_i      (req_i),
    .accept_i   (push && !full),
    .cmd_o      (front_cmd),
    .cmd_push_o (front_push)
  );

  tdb_queue #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(2)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .full_o  (full),
    .wdata_i (front_cmd),
    .empty_o (cmd_empty),
    .pop_i   (cmd_pop),
    .rdata_o (back_cmd)
  );

  tdb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (back_cmd),
    .cmd_valid_i  (!cmd_empty),
    .cmd_pop_o    (cmd_pop),
    .desc_o       (back_desc),
    .desc_valid_o (back_valid),
    .out_full_i   (out_full)
  );

  tdb_queue #(
    .WIDTH($bits(desc_t)),
    .DEPTH(2)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_valid),
    .full_o  (out_full),
    .wdata_i (back_desc),
    .empty_o (empty),
    .pop_i   (pop),
    .rdata_o (desc_o)
  );

endmodule

// ===== rtl/core/tdb_queue.sv =====
// ----------------------------------------------------------------------------
// Transfer descriptor builder queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module tdb_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push_ok, pop_ok;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_ok && !pop_ok) begin
      count_d = count_q + CntW'(1);
    end else if (pop_ok && !push_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/tdb_front.sv =====
// ----------------------------------------------------------------------------
// Transfer descriptor builder front end
// Classifies each request: rejected, empty bulk (dropped) or to be sequenced.
// ----------------------------------------------------------------------------
module tdb_front
  import tdb_pkg::*;
#(
  parameter int MAX_PACKETS = 62
) (
  input  req_t req_i,
  input  logic accept_i,
  output cmd_t cmd_o,
  output logic cmd_push_o
);

  localparam int MpW  = $clog2(MAX_PACKETS + 1);
  localparam int ProdW = MaxpW + MpW;
  localparam int CmpW = (ProdW > CountW) ? ProdW : CountW;

  logic [ProdW-1:0] limit;
  logic             too_many;
  logic             empty_bulk;

  assign limit      = ProdW'(req_i.max_packet) * ProdW'(MAX_PACKETS);
  assign too_many   = CmpW'(req_i.byte_count) > CmpW'(limit);
  assign empty_bulk = req_i.func && (req_i.byte_count == '0);

  always_comb begin
    cmd_o.req    = req_i;
    cmd_o.reject = (req_i.max_packet == '0) || too_many;
  end

  assign cmd_push_o = accept_i && (cmd_o.reject || !empty_bulk);

endmodule

// ===== rtl/core/tdb_back.sv =====
// ----------------------------------------------------------------------------
// Transfer descriptor builder back end
// Sequences a command: SETUP, data, status (control), data (bulk) or a reject.
// ----------------------------------------------------------------------------
module tdb_back
  import tdb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  cmd_i,
  input  logic  cmd_valid_i,
  output logic  cmd_pop_o,
  output desc_t desc_o,
  output logic  desc_valid_o,
  input  logic  out_full_i
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REJ    = 5'b00010,
    S_SETUP  = 5'b00100,
    S_DATA   = 5'b01000,
    S_STATUS = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  logic [CountW-1:0] bytes_left_q, bytes_left_d;
  logic [AddrW-1:0]  next_addr_q, next_addr_d;
  logic              toggle_q, toggle_d;
  logic [MaxpW-1:0]  chunk;
  logic              final_pkt;

  assign final_pkt = bytes_left_q <= CountW'(req_q.max_packet);
  assign chunk     = final_pkt ? bytes_left_q[MaxpW-1:0] : req_q.max_packet;

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    bytes_left_d = bytes_left_q;
    next_addr_d  = next_addr_q;
    toggle_d     = toggle_q;
    cmd_pop_o    = 1'b0;
    desc_valid_o = 1'b0;
    desc_o       = '0;
    desc_o.target_address  = req_q.device_address;
    desc_o.target_endpoint = req_q.endpoint;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o    = 1'b1;
          req_d        = cmd_i.req;
          bytes_left_d = cmd_i.req.byte_count;
          next_addr_d  = cmd_i.req.buffer_address;
          toggle_d     = !cmd_i.req.func;
          if (cmd_i.reject) begin
            state_d = S_REJ;
          end else if (cmd_i.req.func) begin
            state_d = S_DATA;
          end else begin
            state_d = S_SETUP;
          end
        end
      end
      S_REJ: begin
        desc_o          = '0;
        desc_o.rejected = 1'b1;
        desc_o.last     = 1'b1;
        if (!out_full_i) begin
          desc_valid_o = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_SETUP: begin
        desc_o.packet_id    = PID_SETUP;
        desc_o.length_code  = SETUP_LEN_CODE;
        desc_o.short_detect = 1'b1;
        desc_o.data_address = req_q.setup_address;
        if (!out_full_i) begin
          desc_valid_o = 1'b1;
          state_d      = (bytes_left_q == '0) ? S_STATUS : S_DATA;
        end
      end
      S_DATA: begin
        desc_o.packet_id             = req_q.direction ? PID_IN : PID_OUT;
        desc_o.data_toggle           = toggle_q;
        desc_o.length_code           = {1'b0, chunk} - LenW'(1);
        desc_o.short_detect          = 1'b1;
        desc_o.interrupt_on_complete = req_q.func && final_pkt;
        desc_o.data_address          = next_addr_q;
        desc_o.last                  = req_q.func && final_pkt;
        if (!out_full_i) begin
          desc_valid_o = 1'b1;
          bytes_left_d = bytes_left_q - CountW'(chunk);
          next_addr_d  = next_addr_q + AddrW'(chunk);
          toggle_d     = !toggle_q;
          if (final_pkt) begin
            state_d = req_q.func ? S_IDLE : S_STATUS;
          end
        end
      end
      S_STATUS: begin
        desc_o.packet_id             = req_q.direction ? PID_OUT : PID_IN;
        desc_o.data_toggle           = 1'b1;
        desc_o.length_code           = ZERO_LEN_CODE;
        desc_o.interrupt_on_complete = 1'b1;
        desc_o.last                  = 1'b1;
        if (!out_full_i) begin
          desc_valid_o = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    bytes_left_q <= bytes_left_d;
    next_addr_q  <= next_addr_d;
    toggle_q     <= toggle_d;
  end

  a_data_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DATA |-> bytes_left_q != '0)
    else $error("Data stage entered with no bytes left.");

  a_last_ends_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (desc_valid_o && desc_o.last) |=> state_q == S_IDLE)
    else $error("Sequencer kept running after the last descriptor.");

  a_control_toggle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SETUP |-> toggle_q)
    else $error("Control data stage would not start at DATA1.");

  a_no_pop_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (desc_valid_o && !desc_o.last) |=> !cmd_pop_o)
    else $error("New command taken before the request finished.");

endmodule

// ===== test/usb_transfer_descriptor_builder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// USB transfer descriptor builder testbench
// Sends control and bulk transfer requests through the request queue and
// checks every descriptor that leaves the result queue against descriptors
// worked out in the bench, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module usb_transfer_descriptor_builder_test;
  import tdb_pkg::*;

  localparam int MAX_PACKETS = 62;
  localparam logic FUNC_CONTROL = 1'b0;
  localparam logic FUNC_BULK    = 1'b1;
  localparam logic DIR_OUT      = 1'b0;
  localparam logic DIR_IN       = 1'b1;

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  push;
  logic  full;
  req_t  req_i;
  logic  empty;
  logic  pop;
  desc_t desc_o;

  desc_t pending_descs[$];
  int    mismatch_count = 0;
  int    push_gap_max = 5;
  int    pop_stall_max = 5;

  usb_transfer_descriptor_builder #(
    .MAX_PACKETS(MAX_PACKETS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .req_i (req_i),
    .empty (empty),
    .pop   (pop),
    .desc_o(desc_o)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    end
  endtask

  // Works out every descriptor of one accepted request, in order.
  function automatic void build_descriptors(input req_t r);
    desc_t       d;
    int unsigned pkt_count;
    int unsigned left;
    int unsigned chunk;
    logic [31:0] addr;
    logic [1:0]  data_pid;
    logic [1:0]  status_pid;
    logic        bulk;
    logic        final_pkt;
    bulk = (r.func == FUNC_BULK);
    data_pid = (r.direction == DIR_IN) ? PID_IN : PID_OUT;
    status_pid = (r.direction == DIR_IN) ? PID_OUT : PID_IN;
    pkt_count = 0;
    if (r.max_packet != 0) begin
      pkt_count = (int'(r.byte_count) + int'(r.max_packet) - 1) / int'(r.max_packet);
    end
    if (r.max_packet == 0 || pkt_count > MAX_PACKETS) begin
      d = '0;
      d.rejected = 1'b1;
      d.last = 1'b1;
      pending_descs.insert(pending_descs.size(), d);
      return;
    end
    d = '0;
    d.target_address = r.device_address;
    d.target_endpoint = r.endpoint;
    if (!bulk) begin
      d.packet_id = PID_SETUP;
      d.length_code = SETUP_LEN_CODE;
      d.short_detect = 1'b1;
      d.data_address = r.setup_address;
      pending_descs.insert(pending_descs.size(), d);
    end
    left = 32'(r.byte_count);
    addr = r.buffer_address;
    for (int unsigned idx = 0; idx < pkt_count; idx++) begin
      chunk = (left < 32'(r.max_packet)) ? left : 32'(r.max_packet);
      final_pkt = (idx + 1 == pkt_count);
      d.packet_id = data_pid;
      d.data_toggle = bulk ? idx[0] : ~idx[0];
      d.length_code = LenW'(chunk - 1);
      d.short_detect = 1'b1;
      d.interrupt_on_complete = bulk & final_pkt;
      d.data_address = addr;
      d.last = bulk & final_pkt;
      pending_descs.insert(pending_descs.size(), d);
      left -= chunk;
      addr += chunk;
    end
    if (!bulk) begin
      d.packet_id = status_pid;
      d.data_toggle = 1'b1;
      d.length_code = ZERO_LEN_CODE;
      d.short_detect = 1'b0;
      d.interrupt_on_complete = 1'b1;
      d.data_address = '0;
      d.last = 1'b1;
      pending_descs.insert(pending_descs.size(), d);
    end
  endfunction

  task automatic send_request(input req_t r);
    int gap;
    gap = $urandom_range(0, push_gap_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    build_descriptors(r);
  endtask

  function automatic req_t random_request();
    req_t r;
    r.func = 1'($urandom_range(0, 1));
    r.direction = 1'($urandom_range(0, 1));
    r.device_address = 7'($urandom_range(0, 127));
    r.endpoint = 4'($urandom_range(0, 15));
    r.byte_count = 16'($urandom_range(0, 65535));
    r.max_packet = 10'($urandom_range(1, 1023));
    r.buffer_address = $urandom;
    r.setup_address = $urandom;
    return r;
  endfunction

  task automatic send_shaped(input logic func, input logic dir, input int count,
                             input int maxp);
    req_t r;
    r = random_request();
    r.func = func;
    r.direction = dir;
    r.byte_count = 16'(count);
    r.max_packet = 10'(maxp);
    send_request(r);
  endtask

  task automatic test_control_transfers();
    send_shaped(FUNC_CONTROL, DIR_OUT, 20, 8);
    send_shaped(FUNC_CONTROL, DIR_IN, 64, 64);
    send_shaped(FUNC_CONTROL, DIR_IN, 100, 16);
  endtask

  task automatic test_bulk_transfers();
    send_shaped(FUNC_BULK, DIR_OUT, 10, 64);
    send_shaped(FUNC_BULK, DIR_IN, 300, 64);
    send_shaped(FUNC_BULK, DIR_OUT, 128, 32);
  endtask

  task automatic test_empty_requests();
    send_shaped(FUNC_CONTROL, DIR_OUT, 0, 64);
    send_shaped(FUNC_CONTROL, DIR_IN, 0, 8);
    send_shaped(FUNC_BULK, DIR_OUT, 0, 64);
    send_shaped(FUNC_BULK, DIR_IN, 0, 1023);
  endtask

  task automatic test_rejections();
    send_shaped(FUNC_CONTROL, DIR_OUT, 0, 0);
    send_shaped(FUNC_BULK, DIR_IN, 65535, 0);
    send_shaped(FUNC_BULK, DIR_OUT, 63, 1);
    send_shaped(FUNC_CONTROL, DIR_IN, 65535, 1023);
  endtask

  task automatic test_packet_limits();
    send_shaped(FUNC_BULK, DIR_IN, 62, 1);
    send_shaped(FUNC_CONTROL, DIR_OUT, 62 * 1023, 1023);
    send_shaped(FUNC_BULK, DIR_OUT, 61 * 1023 + 1, 1023);
  endtask

  task automatic test_field_extremes();
    req_t r;
    r = random_request();
    r.func = FUNC_BULK;
    r.direction = DIR_IN;
    r.device_address = 7'd127;
    r.endpoint = 4'd15;
    r.buffer_address = 32'hFFFF_FFF0;
    r.byte_count = 40;
    r.max_packet = 16;
    send_request(r);
    r.func = FUNC_CONTROL;
    r.direction = DIR_OUT;
    r.device_address = '0;
    r.endpoint = '0;
    r.buffer_address = '0;
    r.setup_address = 32'hFFFF_FFFF;
    r.byte_count = 33;
    r.max_packet = 32;
    send_request(r);
    r.setup_address = '0;
    r.buffer_address = 32'hFFFF_FFFF;
    r.byte_count = 1023;
    r.max_packet = 1023;
    send_request(r);
    send_shaped(FUNC_BULK, DIR_OUT, 1, 512);
  endtask

  task automatic test_random_requests(input int num_items);
    req_t r;
    int   pick;
    int   n;
    int   lo;
    int   hi;
    for (int i = 0; i < num_items; i++) begin
      if (i % 20 == 0) begin
        push_gap_max = (i % 60 == 20) ? 0 : $urandom_range(1, 5);
        pop_stall_max = (i % 60 == 40) ? 0 : $urandom_range(1, 5);
      end
      r = random_request();
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        r.max_packet = '0;
      end else if (pick < 12) begin
        if (62 * int'(r.max_packet) + 1 > 65535) r.max_packet = 10'($urandom_range(1, 1000));
        r.byte_count = 16'($urandom_range(65535, 62 * int'(r.max_packet) + 1));
      end else if (pick < 18) begin
        r.byte_count = '0;
      end else begin
        r.max_packet = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(1, 64))
                                                 : 10'($urandom_range(1, 1023));
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 62) : $urandom_range(1, 8);
        hi = n * int'(r.max_packet);
        if (hi > 65535) hi = 65535;
        lo = (n - 1) * int'(r.max_packet) + 1;
        if (lo > hi) lo = hi;
        r.byte_count = 16'($urandom_range(hi, lo));
      end
      send_request(r);
    end
    push_gap_max = 5;
    pop_stall_max = 5;
  endtask

  initial begin : result_checker
    desc_t want;
    int    stall;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, pop_stall_max);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      if (pending_descs.size() == 0) begin
        report_mismatch("descriptor arrived with none expected");
      end else begin
        want = pending_descs[0];
        pending_descs.delete(0);
        compare_field("packet_id", 32'(desc_o.packet_id), 32'(want.packet_id));
        compare_field("data_toggle", 32'(desc_o.data_toggle), 32'(want.data_toggle));
        compare_field("target_address", 32'(desc_o.target_address),
                      32'(want.target_address));
        compare_field("target_endpoint", 32'(desc_o.target_endpoint),
                      32'(want.target_endpoint));
        compare_field("length_code", 32'(desc_o.length_code), 32'(want.length_code));
        compare_field("short_detect", 32'(desc_o.short_detect),
                      32'(want.short_detect));
        compare_field("interrupt_on_complete", 32'(desc_o.interrupt_on_complete),
                      32'(want.interrupt_on_complete));
        compare_field("data_address", desc_o.data_address, want.data_address);
        compare_field("rejected", 32'(desc_o.rejected), 32'(want.rejected));
        compare_field("last", 32'(desc_o.last), 32'(want.last));
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    req_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_control_transfers();
    test_bulk_transfers();
    test_empty_requests();
    test_rejections();
    test_packet_limits();
    test_field_extremes();
    test_random_requests(90);
    push <= 1'b0;
    while (pending_descs.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== usb_transfer_descriptor_builder.f =====
rtl/core/tdb_pkg.sv
rtl/core/tdb_queue.sv
rtl/core/tdb_front.sv
rtl/core/tdb_back.sv
rtl/core/usb_transfer_descriptor_builder.sv
test/usb_transfer_descriptor_builder_test.sv
